FILE: rtl/tlpc_pkg.sv
// Shared types, codes and reset constants for the traffic light pedestrian controller.
package tlpc_pkg;

  localparam int unsigned TickW = 3;

  localparam logic [TickW-1:0] GreenTicksDefault  = 3'd5;
  localparam logic [TickW-1:0] YellowTicksDefault = 3'd2;
  localparam logic [TickW-1:0] WaitTicksDefault   = 3'd1;
  localparam logic [TickW-1:0] TickMax            = 3'd7;

  localparam logic [1:0] LightRed    = 2'd0;
  localparam logic [1:0] LightYellow = 2'd1;
  localparam logic [1:0] LightGreen  = 2'd2;
  localparam logic       WalkRed     = 1'b0;
  localparam logic       WalkGreen   = 1'b1;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_BUTTON = 2'd1,
    ACT_EXPIRY = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    BTN_ROAD1 = 2'd1,
    BTN_ROAD2 = 2'd2
  } button_e;

  typedef enum logic [1:0] {
    CFG_GREEN  = 2'd0,
    CFG_YELLOW = 2'd1,
    CFG_WAIT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ANN_NONE  = 3'd0,
    ANN_CARS1 = 3'd1,
    ANN_CARS2 = 3'd2,
    ANN_WALK1 = 3'd3,
    ANN_WALK2 = 3'd4
  } announce_e;

  typedef enum logic [1:0] {
    RELOAD_NONE = 2'd0,
    RELOAD_ONE  = 2'd1,
    RELOAD_TWO  = 2'd2
  } reload_e;

  typedef enum logic [7:0] {
    PH_G1 = 8'b0000_0001,
    PH_Y1 = 8'b0000_0010,
    PH_W1 = 8'b0000_0100,
    PH_G2 = 8'b0000_1000,
    PH_Y2 = 8'b0001_0000,
    PH_W2 = 8'b0010_0000,
    PH_P1 = 8'b0100_0000,
    PH_P2 = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    phase_e           phase;
    logic [TickW-1:0] tick_count;
    logic             req_lock;
    logic             expiry_second;
    logic             ticks_en;
    logic [1:0]       road1_light;
    logic             road1_walk;
    logic [1:0]       road2_light;
    logic             road2_walk;
  } state_t;

  typedef struct packed {
    logic [TickW-1:0] green_ticks;
    logic [TickW-1:0] yellow_ticks;
    logic [TickW-1:0] wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] road1_light;
    logic       road1_walk;
    logic [1:0] road2_light;
    logic       road2_walk;
    logic [2:0] announce;
    logic       phase_tick_run;
    logic       ped_timer_start;
    logic [1:0] ped_timer_reload;
  } result_t;

  localparam state_t StateReset = '{
    phase:         PH_W2,
    tick_count:    '0,
    req_lock:      1'b0,
    expiry_second: 1'b0,
    ticks_en:      1'b1,
    road1_light:   LightRed,
    road1_walk:    WalkRed,
    road2_light:   LightRed,
    road2_walk:    WalkGreen
  };

endpackage

FILE: rtl/tlpc_step.sv
// Next-state and result logic for one controller event.
module tlpc_step (
  input  tlpc_pkg::state_t  cur_i,
  input  tlpc_pkg::cfg_t    cfg_i,
  input  logic [1:0]        action_i,
  input  logic [1:0]        button_id_i,
  output tlpc_pkg::state_t  nxt_o,
  output tlpc_pkg::result_t res_o
);
  import tlpc_pkg::*;

  logic [TickW-1:0] cnt_inc;
  logic [2:0]       ann;
  logic             start;
  logic [1:0]       reload;

  assign cnt_inc = (cur_i.tick_count == TickMax) ? TickMax : cur_i.tick_count + 3'd1;

  always_comb begin
    nxt_o  = cur_i;
    ann    = ANN_NONE;
    start  = 1'b0;
    reload = RELOAD_NONE;
    unique case (action_i)
      ACT_TICK: begin
        if (cur_i.ticks_en) begin
          nxt_o.tick_count = cnt_inc;
          unique case (cur_i.phase)
            PH_W1: begin
              if (cnt_inc >= cfg_i.wait_ticks) begin
                nxt_o.road2_light = LightGreen;
                nxt_o.road2_walk  = WalkRed;
                nxt_o.phase       = PH_G2;
                nxt_o.tick_count  = '0;
                ann               = ANN_CARS2;
              end
            end
            PH_W2: begin
              if (cnt_inc >= cfg_i.wait_ticks) begin
                nxt_o.road1_light = LightGreen;
                nxt_o.road1_walk  = WalkRed;
                nxt_o.phase       = PH_G1;
                nxt_o.tick_count  = '0;
                ann               = ANN_CARS1;
              end
            end
            PH_G1: begin
              if (cnt_inc >= cfg_i.green_ticks) begin
                nxt_o.road1_light = LightYellow;
                nxt_o.phase       = PH_Y1;
                nxt_o.tick_count  = '0;
              end
            end
            PH_G2: begin
              if (cnt_inc >= cfg_i.green_ticks) begin
                nxt_o.road2_light = LightYellow;
                nxt_o.phase       = PH_Y2;
                nxt_o.tick_count  = '0;
              end
            end
            PH_Y1: begin
              if (cnt_inc >= cfg_i.yellow_ticks) begin
                nxt_o.road1_light = LightRed;
                nxt_o.road1_walk  = WalkGreen;
                nxt_o.phase       = PH_W1;
                nxt_o.tick_count  = '0;
              end
            end
            PH_Y2: begin
              if (cnt_inc >= cfg_i.yellow_ticks) begin
                nxt_o.road2_light = LightRed;
                nxt_o.road2_walk  = WalkGreen;
                nxt_o.phase       = PH_W2;
                nxt_o.tick_count  = '0;
              end
            end
            default: begin
              // pedestrian phases only count
            end
          endcase
        end
      end
      ACT_BUTTON: begin
        priority if (button_id_i == BTN_ROAD1 && cur_i.phase == PH_G1 && !cur_i.req_lock) begin
          nxt_o.req_lock    = 1'b1;
          nxt_o.phase       = PH_P1;
          nxt_o.ticks_en    = 1'b0;
          nxt_o.road1_light = LightRed;
          nxt_o.road1_walk  = WalkGreen;
          ann               = ANN_WALK1;
          start             = 1'b1;
        end else if (button_id_i == BTN_ROAD2 && cur_i.phase == PH_G2 &&
                     !cur_i.req_lock) begin
          nxt_o.req_lock    = 1'b1;
          nxt_o.phase       = PH_P2;
          nxt_o.ticks_en    = 1'b0;
          nxt_o.road2_light = LightRed;
          nxt_o.road2_walk  = WalkGreen;
          ann               = ANN_WALK2;
          start             = 1'b1;
        end else begin
        end
      end
      ACT_EXPIRY: begin
        if (!cur_i.expiry_second) begin
          nxt_o.ticks_en = 1'b1;
          if (cur_i.phase == PH_P1) begin
            nxt_o.phase       = PH_G1;
            nxt_o.road1_walk  = WalkRed;
            nxt_o.road1_light = LightGreen;
            ann               = ANN_CARS1;
          end else if (cur_i.phase == PH_P2) begin
            nxt_o.phase       = PH_G2;
            nxt_o.road2_walk  = WalkRed;
            nxt_o.road2_light = LightGreen;
            ann               = ANN_CARS2;
          end
          reload              = RELOAD_ONE;
          start               = 1'b1;
          nxt_o.expiry_second = 1'b1;
        end else begin
          nxt_o.req_lock      = 1'b0;
          reload              = RELOAD_TWO;
          nxt_o.expiry_second = 1'b0;
        end
      end
      default: begin
        // unused action code: no change
      end
    endcase
  end

  assign res_o = '{
    road1_light:      nxt_o.road1_light,
    road1_walk:       nxt_o.road1_walk,
    road2_light:      nxt_o.road2_light,
    road2_walk:       nxt_o.road2_walk,
    announce:         ann,
    phase_tick_run:   nxt_o.ticks_en,
    ped_timer_start:  start,
    ped_timer_reload: reload
  };

endmodule

FILE: rtl/traffic_light_pedestrian_controller_unit.sv
// Top level of the two-road traffic light controller with pedestrian requests.
//
// Usage:
//  - Event channel (in_valid_i / in_stall_o): action_i and button_id_i, one
//    event per request. Every event gives exactly one result.
//  - Result channel (out_valid_o / out_stall_i): the lights after the event,
//    the announce code, the phase tick enable and pedestrian timer controls.
//  - Config channel (cfg_valid_i / cfg_ready_o): cfg_index_i 0 green, 1 yellow,
//    2 wait tick counts; other indexes are dropped. Always ready; write only
//    while no event is in flight.
//  - An accepted event goes into the input register, then its state update
//    lands in the result register.
//  - Throughput is one event per cycle while the receiver does not stall; the
//    input register and the result register form a two-deep pipe, so a new
//    event is taken while a result waits. in_stall_o rises only when both
//    stages hold a request and the receiver stalls.
//  - Reset puts road two in its all-red wait (road two walk green), tick
//    count zero, lock clear, phase ticks enabled, and tick counts 5/2/1.
module traffic_light_pedestrian_controller_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [1:0] button_id_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] road1_light_o,
  output logic       road1_walk_o,
  output logic [1:0] road2_light_o,
  output logic       road2_walk_o,
  output logic [2:0] announce_o,
  output logic       phase_tick_run_o,
  output logic       ped_timer_start_o,
  output logic [1:0] ped_timer_reload_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [2:0] cfg_data_i
);
  import tlpc_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_action_q;
  logic [1:0] s1_button_q;
  logic       out_valid_q, out_valid_d;
  result_t    res_q, res_d;
  state_t     state_q, state_d;
  cfg_t       cfg_q;
  logic       in_accept;
  logic       advance;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  tlpc_step u_step (
    .cur_i       (state_q),
    .cfg_i       (cfg_q),
    .action_i    (s1_action_q),
    .button_id_i (s1_button_q),
    .nxt_o       (state_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_button_q <= button_id_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_ticks  <= GreenTicksDefault;
      cfg_q.yellow_ticks <= YellowTicksDefault;
      cfg_q.wait_ticks   <= WaitTicksDefault;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_GREEN:  cfg_q.green_ticks  <= cfg_data_i;
        CFG_YELLOW: cfg_q.yellow_ticks <= cfg_data_i;
        CFG_WAIT:   cfg_q.wait_ticks   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign road1_light_o      = res_q.road1_light;
  assign road1_walk_o       = res_q.road1_walk;
  assign road2_light_o      = res_q.road2_light;
  assign road2_walk_o       = res_q.road2_walk;
  assign announce_o         = res_q.announce;
  assign phase_tick_run_o   = res_q.phase_tick_run;
  assign ped_timer_start_o  = res_q.ped_timer_start;
  assign ped_timer_reload_o = res_q.ped_timer_reload;

  // a pedestrian phase always runs with phase ticks stopped
  a_ped_ticks_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_P1 || state_q.phase == PH_P2) |-> !state_q.ticks_en)
    else $error("phase ticks enabled during pedestrian phase");

  a_road1_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.road1_light == LightGreen) == (state_q.phase == PH_G1))
    else $error("road one green light out of step with phase");

  a_road2_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.road2_light == LightGreen) == (state_q.phase == PH_G2))
    else $error("road two green light out of step with phase");

  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("request left input stage without reaching result register");

endmodule
